### rtl/core/lpac_pkg.sv
// Shared types, constants and helper functions of the label pair adjacency counter.
`default_nettype none
package lpac_pkg;

	localparam int VERTEX_W = 12;
	localparam int LABEL_W = 5;
	localparam int NUM_LABELS = 32;
	localparam int NUM_VERTICES = 4096;
	localparam int SLOT_W = 2 * LABEL_W;
	localparam int NUM_SLOTS = NUM_LABELS * NUM_LABELS;
	localparam int COUNT_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd10;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_FACE = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] EDGE_AB = 2'd0;
	localparam logic [1:0] EDGE_BC = 2'd1;
	localparam logic [1:0] EDGE_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QWAIT,
		ST_FB,
		ST_FC,
		ST_FL,
		ST_ER,
		ST_EW,
		ST_FINISH
	} state_t;

	// The smaller label selects the row and the larger one the column.
	function automatic logic [SLOT_W-1:0] pair_slot(input logic [LABEL_W-1:0] x,
			input logic [LABEL_W-1:0] y);
		logic [LABEL_W-1:0] lo;
		logic [LABEL_W-1:0] hi;
		lo = (x < y) ? x : y;
		hi = (x < y) ? y : x;
		return {lo, hi};
	endfunction

endpackage
`default_nettype wire

### rtl/core/lpac_in_if.sv
// Input channel of the label pair adjacency counter: handshake and item fields.
`default_nettype none
interface lpac_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [lpac_pkg::VERTEX_W-1:0] vertex_index;
	logic [lpac_pkg::LABEL_W-1:0] label_value;
	logic [lpac_pkg::VERTEX_W-1:0] corner_a;
	logic [lpac_pkg::VERTEX_W-1:0] corner_b;
	logic [lpac_pkg::VERTEX_W-1:0] corner_c;
	logic [lpac_pkg::LABEL_W-1:0] query_first;
	logic [lpac_pkg::LABEL_W-1:0] query_second;

	modport source (
		output valid, func, vertex_index, label_value, corner_a, corner_b, corner_c,
			query_first, query_second,
		input ready
	);

	modport sink (
		input valid, func, vertex_index, label_value, corner_a, corner_b, corner_c,
			query_first, query_second,
		output ready
	);
endinterface
`default_nettype wire

### rtl/core/lpac_out_if.sv
// Result channel of the label pair adjacency counter: handshake and result fields.
`default_nettype none
interface lpac_out_if;
	logic valid;
	logic ready;
	logic adjacent;
	logic [lpac_pkg::COUNT_W-1:0] shared_count;

	modport source (
		output valid, adjacent, shared_count,
		input ready
	);

	modport sink (
		input valid, adjacent, shared_count,
		output ready
	);
endinterface
`default_nettype wire

### rtl/core/lpac_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module lpac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/label_pair_adjacency_counter_core.sv
// Top level of the label pair adjacency counter: sequencer, label store and counter store.
//
// Channel   Direction  Carries
// req       in         func, vertex_index, label_value, corner_a/b/c, query_first/second
// rsp       out        adjacent, shared_count
// cfg       in         cfg_we, cfg_wdata (adjacency threshold)
//
// A load goes from idle straight to the finish step, and a query first passes through
// a wait step for the registered read of the counter RAM. A face reads its three corner
// labels in turn and then takes each edge through a read step and, if its labels
// differ, a write step, since all counter updates share the one read and write port
// of the counter RAM. After reset all 1024 counter RAM entries are cleared one entry
// a cycle, and req.ready stays low during that pass.
// One finished result is buffered; the sequencer waits only when it is still held.
`default_nettype none
module label_pair_adjacency_counter_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lpac_pkg::COUNT_W-1:0]  cfg_wdata,
	lpac_in_if.sink                            req,
	lpac_out_if.source                         rsp
);

	lpac_pkg::state_t state_q;
	lpac_pkg::state_t state_d;

	logic [lpac_pkg::SLOT_W-1:0]   clr_q;
	logic [1:0]                    edge_q;
	logic [lpac_pkg::LABEL_W-1:0]  lab_a_q;
	logic [lpac_pkg::LABEL_W-1:0]  lab_b_q;
	logic [lpac_pkg::LABEL_W-1:0]  lab_c_q;
	logic [lpac_pkg::VERTEX_W-1:0] corner_b_q;
	logic [lpac_pkg::VERTEX_W-1:0] corner_c_q;
	logic                          qeq_q;
	logic                          adj_q;
	logic [lpac_pkg::COUNT_W-1:0]  cnt_q;
	logic [lpac_pkg::COUNT_W-1:0]  thr_q;
	logic                          rsp_valid_q;
	logic                          rsp_adj_q;
	logic [lpac_pkg::COUNT_W-1:0]  rsp_cnt_q;

	logic                          accept;
	logic                          finish_go;
	logic                          edge_inc;
	logic [lpac_pkg::LABEL_W-1:0]  op_x;
	logic [lpac_pkg::LABEL_W-1:0]  op_y;
	logic                          op_eq;
	logic [lpac_pkg::SLOT_W-1:0]   slot;

	logic                          lab_we;
	logic [lpac_pkg::VERTEX_W-1:0] lab_raddr;
	logic [lpac_pkg::LABEL_W-1:0]  lab_rdata;
	logic                          cnt_we;
	logic [lpac_pkg::SLOT_W-1:0]   cnt_waddr;
	logic [lpac_pkg::COUNT_W-1:0]  cnt_wdata;
	logic [lpac_pkg::COUNT_W-1:0]  cnt_rdata;
	logic [lpac_pkg::COUNT_W-1:0]  cnt_inc;

	assign accept = req.valid && req.ready;
	assign finish_go = (state_q == lpac_pkg::ST_FINISH) && (!rsp_valid_q || rsp.ready);

	// One pair-ordering unit serves the query lookup and every face edge.
	always_comb begin
		if (state_q == lpac_pkg::ST_IDLE) begin
			op_x = req.query_first;
			op_y = req.query_second;
		end else begin
			case (edge_q)
				lpac_pkg::EDGE_AB: begin
					op_x = lab_a_q;
					op_y = lab_b_q;
				end
				lpac_pkg::EDGE_BC: begin
					op_x = lab_b_q;
					op_y = lab_c_q;
				end
				default: begin
					op_x = lab_c_q;
					op_y = lab_a_q;
				end
			endcase
		end
	end

	assign op_eq = (op_x == op_y);
	assign slot = lpac_pkg::pair_slot(op_x, op_y);
	assign cnt_inc = (cnt_rdata == lpac_pkg::COUNT_MAX) ? cnt_rdata
		: cnt_rdata + lpac_pkg::COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpac_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		lab_we = 1'b0;
		lab_raddr = corner_c_q;
		cnt_we = 1'b0;
		cnt_waddr = slot;
		cnt_wdata = cnt_inc;
		edge_inc = 1'b0;
		case (state_q)
			lpac_pkg::ST_CLEAR: begin
				cnt_we = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
				if (clr_q == '1) begin
					state_d = lpac_pkg::ST_IDLE;
				end
			end
			lpac_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				lab_raddr = req.corner_a;
				if (req.valid) begin
					case (req.func)
						lpac_pkg::FUNC_LOAD: begin
							lab_we = 1'b1;
							state_d = lpac_pkg::ST_FINISH;
						end
						lpac_pkg::FUNC_FACE: state_d = lpac_pkg::ST_FB;
						lpac_pkg::FUNC_QUERY: state_d = lpac_pkg::ST_QWAIT;
						default: state_d = lpac_pkg::ST_FINISH;
					endcase
				end
			end
			lpac_pkg::ST_QWAIT: state_d = lpac_pkg::ST_FINISH;
			lpac_pkg::ST_FB: begin
				lab_raddr = corner_b_q;
				state_d = lpac_pkg::ST_FC;
			end
			lpac_pkg::ST_FC: begin
				lab_raddr = corner_c_q;
				state_d = lpac_pkg::ST_FL;
			end
			lpac_pkg::ST_FL: state_d = lpac_pkg::ST_ER;
			lpac_pkg::ST_ER: begin
				if (op_eq) begin
					if (edge_q == lpac_pkg::EDGE_LAST) begin
						state_d = lpac_pkg::ST_FINISH;
					end else begin
						edge_inc = 1'b1;
					end
				end else begin
					state_d = lpac_pkg::ST_EW;
				end
			end
			lpac_pkg::ST_EW: begin
				cnt_we = 1'b1;
				if (edge_q == lpac_pkg::EDGE_LAST) begin
					state_d = lpac_pkg::ST_FINISH;
				end else begin
					edge_inc = 1'b1;
					state_d = lpac_pkg::ST_ER;
				end
			end
			lpac_pkg::ST_FINISH: begin
				if (finish_go) begin
					state_d = lpac_pkg::ST_IDLE;
				end
			end
			default: state_d = lpac_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			edge_q <= lpac_pkg::EDGE_AB;
			thr_q <= lpac_pkg::THRESHOLD_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == lpac_pkg::ST_CLEAR) begin
				clr_q <= clr_q + lpac_pkg::SLOT_W'(1);
			end
			if (accept) begin
				edge_q <= lpac_pkg::EDGE_AB;
			end else if (edge_inc) begin
				edge_q <= edge_q + 2'd1;
			end
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (finish_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			corner_b_q <= req.corner_b;
			corner_c_q <= req.corner_c;
			qeq_q <= op_eq;
			adj_q <= 1'b0;
			cnt_q <= '0;
		end
		case (state_q)
			lpac_pkg::ST_FB: lab_a_q <= lab_rdata;
			lpac_pkg::ST_FC: lab_b_q <= lab_rdata;
			lpac_pkg::ST_FL: lab_c_q <= lab_rdata;
			lpac_pkg::ST_QWAIT: begin
				if (!qeq_q) begin
					cnt_q <= cnt_rdata;
					adj_q <= (cnt_rdata >= thr_q);
				end
			end
			default: begin
			end
		endcase
		if (finish_go) begin
			rsp_adj_q <= adj_q;
			rsp_cnt_q <= cnt_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.adjacent = rsp_adj_q;
	assign rsp.shared_count = rsp_cnt_q;

	lpac_ram #(
		.WIDTH (lpac_pkg::LABEL_W),
		.DEPTH (lpac_pkg::NUM_VERTICES)
	) u_label_ram (
		.clk   (clk),
		.we    (lab_we),
		.waddr (req.vertex_index),
		.wdata (req.label_value),
		.raddr (lab_raddr),
		.rdata (lab_rdata)
	);

	lpac_ram #(
		.WIDTH (lpac_pkg::COUNT_W),
		.DEPTH (lpac_pkg::NUM_SLOTS)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (slot),
		.rdata (cnt_rdata)
	);

`ifndef ASSERT_OFF
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpac_pkg::ST_CLEAR) |-> !req.ready)
		else $error("Input transaction accepted during the counter clearing pass.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("Input ready again in the cycle after an accepted transaction.");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == lpac_pkg::ST_FINISH))
		else $error("Result raised outside the finish step.");

	a_count_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (state_q == lpac_pkg::ST_CLEAR || state_q == lpac_pkg::ST_EW))
		else $error("Counter RAM written outside clearing or edge update.");
`endif

endmodule
`default_nettype wire
